// File: design/dtbcd_pkg.sv
package dtbcd_pkg;

   // One input transaction: calendar date and time in plain binary
   typedef struct packed {
      logic [7:0]  second_in;
      logic [7:0]  minute_in;
      logic [7:0]  hour_in;
      logic [7:0]  day_in;
      logic [7:0]  month_in;
      logic [11:0] year_in;
   } req_type;

   // One result transaction: RTC time-keeping register image
   typedef struct packed {
      logic [6:0] seconds_bcd;
      logic [6:0] minutes_bcd;
      logic [5:0] hours_bcd;
      logic [2:0] weekday;
      logic [5:0] date_bcd;
      logic [4:0] month_bcd;
      logic [7:0] year_bcd;
   } rsp_type;

   // Saturation limits
   localparam logic [7:0]  SEC_MAX   = 8'd59;
   localparam logic [7:0]  MIN_MAX   = 8'd59;
   localparam logic [7:0]  HOUR_MAX  = 8'd23;
   localparam logic [7:0]  DAY_MAX   = 8'd31;
   localparam logic [7:0]  MON_MAX   = 8'd12;
   localparam logic [11:0] YEAR_LO   = 12'd2000;
   localparam logic [11:0] YEAR_HI   = 12'd2099;

   // Zeller: January and February count as months 13 and 14 of the prior year
   localparam logic [7:0]  MON_FEB       = 8'd2;
   localparam logic [3:0]  MON_SHIFT     = 4'd12;
   // Year 1999 splits into k = 99, j = 19
   localparam logic [6:0]  K_PREV_CENT   = 7'd99;
   // j/4 + 5*j for j = 19 and j = 20
   localparam logic [8:0]  CENT_TERM_19  = 9'd99;
   localparam logic [8:0]  CENT_TERM_20  = 9'd105;
   localparam logic [2:0]  WDAY_SAT      = 3'd7;

   // Packed BCD of a value 0..99; tens digit by reciprocal multiply (205/2048)
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

   // floor(13 * (mm + 1) / 5) for mm = 3..14
   function automatic logic [5:0] month_term(input logic [3:0] mm);
      logic [5:0] t;
      case (mm)
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         4'd13:   t = 6'd36;
         4'd14:   t = 6'd39;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   // Remainder by 7 for values up to 511; quotient by 293/2048
   function automatic logic [2:0] mod7(input logic [8:0] s);
      logic [17:0] prod;
      logic [6:0]  q;
      logic [8:0]  r;
      prod = 18'(s) * 18'd293;
      q    = prod[17:11];
      r    = s - 9'(q) * 9'd7;
      return r[2:0];
   endfunction

endpackage

// File: design/datetime_to_bcd_rtc_image.sv
// Channel   Direction  Payload                  Handshake
// req_      in         dtbcd_pkg::req_type      req_valid / req_stall
// rsp_      out        dtbcd_pkg::rsp_type      rsp_valid / rsp_stall
//
// One transaction per cycle while rsp_stall is low; accepted transactions go
// via the input register and clamp/BCD/weekday logic to the result register.
// Synchronous active-high reset clears both valid flags; payloads are not reset.
// A stalled result holds in the result register while the input register still
// takes one more transaction; req_stall rises only when both registers are full.
module datetime_to_bcd_rtc_image (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dtbcd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dtbcd_pkg::rsp_type rsp_data
);

   logic               s1_valid_ff, s1_valid_in;
   dtbcd_pkg::req_type s1_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   dtbcd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               out_free;
   logic               req_take;

   logic [7:0]  sec_c, min_c, hr_c, day_c, mon_c;
   logic [11:0] yr_c;
   logic [6:0]  yoff;
   logic        early;
   logic [3:0]  mm;
   logic [6:0]  k;
   logic [8:0]  cent;
   logic [8:0]  zsum;
   logic [2:0]  h;
   logic [7:0]  sec_b, min_b, hr_b, day_b, mon_b, yr_b;

   // Handshake: result register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // Clamp fields from above, year from both sides
   always_comb begin
      sec_c = (s1_data_ff.second_in > dtbcd_pkg::SEC_MAX) ? dtbcd_pkg::SEC_MAX
                                                           : s1_data_ff.second_in;
      min_c = (s1_data_ff.minute_in > dtbcd_pkg::MIN_MAX) ? dtbcd_pkg::MIN_MAX
                                                           : s1_data_ff.minute_in;
      hr_c  = (s1_data_ff.hour_in > dtbcd_pkg::HOUR_MAX) ? dtbcd_pkg::HOUR_MAX
                                                          : s1_data_ff.hour_in;
      day_c = (s1_data_ff.day_in > dtbcd_pkg::DAY_MAX) ? dtbcd_pkg::DAY_MAX
                                                        : s1_data_ff.day_in;
      mon_c = (s1_data_ff.month_in > dtbcd_pkg::MON_MAX) ? dtbcd_pkg::MON_MAX
                                                          : s1_data_ff.month_in;
      if (s1_data_ff.year_in > dtbcd_pkg::YEAR_HI) begin
         yr_c = dtbcd_pkg::YEAR_HI;
      end else if (s1_data_ff.year_in < dtbcd_pkg::YEAR_LO) begin
         yr_c = dtbcd_pkg::YEAR_LO;
      end else begin
         yr_c = s1_data_ff.year_in;
      end
      yoff = 7'(yr_c - dtbcd_pkg::YEAR_LO);
   end

   // Zeller's congruence; months 0..2 belong to the previous year
   always_comb begin
      early = (mon_c <= dtbcd_pkg::MON_FEB);
      mm    = early ? (mon_c[3:0] + dtbcd_pkg::MON_SHIFT) : mon_c[3:0];
      if (early && (yoff == 7'd0)) begin
         k    = dtbcd_pkg::K_PREV_CENT;
         cent = dtbcd_pkg::CENT_TERM_19;
      end else begin
         k    = yoff - 7'(early);
         cent = dtbcd_pkg::CENT_TERM_20;
      end
      zsum = 9'(day_c) + 9'(dtbcd_pkg::month_term(mm)) + 9'(k) + 9'(k[6:2]) + cent;
      h    = dtbcd_pkg::mod7(zsum);
   end

   // BCD encode and build result
   always_comb begin
      sec_b = dtbcd_pkg::to_bcd(sec_c[6:0]);
      min_b = dtbcd_pkg::to_bcd(min_c[6:0]);
      hr_b  = dtbcd_pkg::to_bcd(hr_c[6:0]);
      day_b = dtbcd_pkg::to_bcd(day_c[6:0]);
      mon_b = dtbcd_pkg::to_bcd(mon_c[6:0]);
      yr_b  = dtbcd_pkg::to_bcd(yoff);
      rsp_data_in.seconds_bcd = sec_b[6:0];
      rsp_data_in.minutes_bcd = min_b[6:0];
      rsp_data_in.hours_bcd   = hr_b[5:0];
      // Zeller h = 0 is Saturday
      rsp_data_in.weekday     = (h == 3'd0) ? dtbcd_pkg::WDAY_SAT : h;
      rsp_data_in.date_bcd    = day_b[5:0];
      rsp_data_in.month_bcd   = mon_b[4:0];
      rsp_data_in.year_bcd    = yr_b;
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (out_free && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Input side stalls only with both registers full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_stall with a free register");

   // An accepted transaction lands in the input register
   a_take_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted transaction lost");

   // A moving input register fills the result register
   a_move_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_free) |=> (rsp_valid_ff && (rsp_data_ff == $past(rsp_data_in))))
      else $error("transaction not moved to result register");

   // Weekday stays in 1..7
   a_wday: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.weekday != 3'd0))
      else $error("weekday zero");

   // Low BCD digits of seconds, date and year stay decimal
   a_bcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.seconds_bcd[3:0] <= 4'd9)
                        && (rsp_data_ff.year_bcd[3:0] <= 4'd9)
                        && (rsp_data_ff.date_bcd[3:0] <= 4'd9)))
      else $error("BCD digit out of range");
`endif

endmodule

// File: dv/tb_datetime_to_bcd_rtc_image.sv
module tb_datetime_to_bcd_rtc_image;

   localparam int RANDOM_PER_PHASE = 430;
   localparam int QUIET_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 10;
   localparam logic [2:0] WDAY_THU = 3'd5;

   // One row of the directed table; want is only trusted when known is set
   typedef struct {
      dtbcd_pkg::req_type stim;
      bit                 known;
      dtbcd_pkg::rsp_type want;
   } vector_row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   dtbcd_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   dtbcd_pkg::rsp_type rsp_data;

   // Expected image travels alongside the request payload
   bit                 row_known = 1'b0;
   dtbcd_pkg::rsp_type row_want  = '0;

   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int fail_count   = 0;
   int quiet_cycles = 0;

   dtbcd_pkg::rsp_type image_q[$];
   vector_row_type     vectors[$];

   datetime_to_bcd_rtc_image u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Two decimal digits, tens in the upper nibble
   function automatic logic [7:0] pack_bcd(input int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Clamp, encode, and derive weekday by Zeller's congruence
   function automatic dtbcd_pkg::rsp_type encode_rtc_image(input dtbcd_pkg::req_type r);
      dtbcd_pkg::rsp_type o;
      int unsigned        sec, mins, hr, day, mon, yr, yy, mm, k, j, h;
      sec  = (r.second_in > dtbcd_pkg::SEC_MAX)  ? dtbcd_pkg::SEC_MAX  : r.second_in;
      mins = (r.minute_in > dtbcd_pkg::MIN_MAX)  ? dtbcd_pkg::MIN_MAX  : r.minute_in;
      hr   = (r.hour_in   > dtbcd_pkg::HOUR_MAX) ? dtbcd_pkg::HOUR_MAX : r.hour_in;
      day  = (r.day_in    > dtbcd_pkg::DAY_MAX)  ? dtbcd_pkg::DAY_MAX  : r.day_in;
      mon  = (r.month_in  > dtbcd_pkg::MON_MAX)  ? dtbcd_pkg::MON_MAX  : r.month_in;
      yr   = (r.year_in   > dtbcd_pkg::YEAR_HI)  ? dtbcd_pkg::YEAR_HI  : r.year_in;
      if (yr < dtbcd_pkg::YEAR_LO) begin
         yr = dtbcd_pkg::YEAR_LO;
      end
      // Jan, Feb and month zero count as late months of the prior year
      yy = yr;
      mm = mon;
      if (mon <= 2) begin
         yy = yr - 1;
         mm = mon + 12;
      end
      k = yy % 100;
      j = yy / 100;
      h = (day + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      o.seconds_bcd = 7'(pack_bcd(sec));
      o.minutes_bcd = 7'(pack_bcd(mins));
      o.hours_bcd   = 6'(pack_bcd(hr));
      o.weekday     = 3'((h + 6) % 7 + 1);
      o.date_bcd    = 6'(pack_bcd(day));
      o.month_bcd   = 5'(pack_bcd(mon));
      o.year_bcd    = pack_bcd(yr - dtbcd_pkg::YEAR_LO);
      return o;
   endfunction

   function automatic void add_vector(input bit known, input dtbcd_pkg::rsp_type want,
                                      input int unsigned s, mi, h, d, mo, y);
      vector_row_type row;
      row.stim  = {8'(s), 8'(mi), 8'(h), 8'(d), 8'(mo), 12'(y)};
      row.known = known;
      row.want  = want;
      vectors.push_back(row);
   endfunction

   // Mostly in range, some right at the clamp edge, some raw bits
   function automatic logic [7:0] pick_field(input int unsigned hi);
      case ($urandom_range(0, 7))
         0:       return 8'($urandom);
         1:       return 8'(hi + $urandom_range(0, 1));
         default: return 8'($urandom_range(0, hi));
      endcase
   endfunction

   function automatic logic [11:0] pick_year();
      case ($urandom_range(0, 7))
         0:       return 12'($urandom);
         1:       return 12'(dtbcd_pkg::YEAR_LO - 1 + $urandom_range(0, 1));
         2:       return 12'(dtbcd_pkg::YEAR_HI + $urandom_range(0, 1));
         default: return 12'(dtbcd_pkg::YEAR_LO + $urandom_range(0, 99));
      endcase
   endfunction

   function automatic dtbcd_pkg::req_type make_random_request();
      dtbcd_pkg::req_type r;
      r.second_in = pick_field(dtbcd_pkg::SEC_MAX);
      r.minute_in = pick_field(dtbcd_pkg::MIN_MAX);
      r.hour_in   = pick_field(dtbcd_pkg::HOUR_MAX);
      r.day_in    = pick_field(dtbcd_pkg::DAY_MAX);
      r.month_in  = pick_field(dtbcd_pkg::MON_MAX);
      r.year_in   = pick_year();
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                  $time, name, want, got);
         fail_count++;
      end
   endtask

   // Present one transaction, with random idle cycles ahead of it
   task automatic send_item(input dtbcd_pkg::req_type r, input bit known,
                            input dtbcd_pkg::rsp_type want);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      row_known <= known;
      row_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every outstanding image has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (image_q.size() != 0) @(posedge clock);
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   // Scoreboard and watchdog
   always @(posedge clock) begin
      dtbcd_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            image_q.push_back(row_known ? row_want : encode_rtc_image(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (image_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual 'h%0h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = image_q.pop_front();
               check_field("seconds_bcd", want.seconds_bcd, rsp_data.seconds_bcd);
               check_field("minutes_bcd", want.minutes_bcd, rsp_data.minutes_bcd);
               check_field("hours_bcd",   want.hours_bcd,   rsp_data.hours_bcd);
               check_field("weekday",     want.weekday,     rsp_data.weekday);
               check_field("date_bcd",    want.date_bcd,    rsp_data.date_bcd);
               check_field("month_bcd",   want.month_bcd,   rsp_data.month_bcd);
               check_field("year_bcd",    want.year_bcd,    rsp_data.year_bcd);
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("** datetime_to_bcd_rtc_image: FAILED **");
         $finish;
      end
   end

   initial begin
      // First of the century was a Saturday
      add_vector(1'b1, {7'h00, 7'h00, 6'h00, dtbcd_pkg::WDAY_SAT, 6'h01, 5'h01, 8'h00},
                 0, 0, 0, 1, 1, 2000);
      // Everything saturated lands on 2099-12-31 23:59:59, a Thursday
      add_vector(1'b1, {7'h59, 7'h59, 6'h23, WDAY_THU, 6'h31, 5'h12, 8'h99},
                 255, 255, 255, 255, 255, 4095);
      add_vector(1'b1, {7'h59, 7'h59, 6'h23, WDAY_THU, 6'h31, 5'h12, 8'h99},
                 59, 59, 23, 31, 12, 2099);
      add_vector(1'b1, {7'h59, 7'h59, 6'h23, WDAY_THU, 6'h31, 5'h12, 8'h99},
                 60, 60, 24, 32, 13, 2100);
      // Zero day, zero month, year below the window
      add_vector(1'b0, '0, 0, 0, 0, 0, 0, 0);
      add_vector(1'b0, '0, 30, 15, 12, 0, 3, 2024);
      add_vector(1'b0, '0, 0, 0, 0, 15, 0, 2050);
      add_vector(1'b0, '0, 0, 0, 0, 0, 0, 2000);
      add_vector(1'b0, '0, 0, 0, 0, 1, 1, 0);
      add_vector(1'b0, '0, 9, 9, 9, 9, 9, 1999);
      // Day past month end, leap day, month and century boundaries
      add_vector(1'b0, '0, 12, 34, 56, 31, 4, 2023);
      add_vector(1'b0, '0, 1, 1, 1, 30, 2, 2024);
      add_vector(1'b0, '0, 59, 0, 23, 29, 2, 2024);
      add_vector(1'b0, '0, 0, 59, 0, 1, 3, 2000);
      add_vector(1'b0, '0, 10, 20, 9, 31, 12, 2000);
      add_vector(1'b0, '0, 45, 5, 18, 1, 1, 2001);
      add_vector(1'b0, '0, 19, 29, 19, 19, 10, 2019);
      add_vector(1'b0, '0, 1, 1, 1, 28, 2, 2100);
      // Alternating bit patterns
      add_vector(1'b0, '0, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'hAA, 12'hAAA);
      add_vector(1'b0, '0, 8'h55, 8'hAA, 8'h55, 8'h55, 8'h55, 12'h555);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 31;
      rx_idle_pct = 67;
      foreach (vectors[i]) begin
         send_item(vectors[i].stim, vectors[i].known, vectors[i].want);
      end
      wait_drained();

      // Random traffic under three idle patterns
      for (int idle_mode = 0; idle_mode < 3; idle_mode++) begin
         case (idle_mode)
            0: begin
               tx_idle_pct = 31;
               rx_idle_pct = 67;
            end
            1: begin
               tx_idle_pct = 67;
               rx_idle_pct = 31;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            send_item(make_random_request(), 1'b0, '0);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** datetime_to_bcd_rtc_image: PASSED **");
      end else begin
         $display("** datetime_to_bcd_rtc_image: FAILED **");
      end
      $finish;
   end

endmodule
